[rtl/h2r_pkg.sv]
// h2r_pkg: shared codes for the HSL to RGB converter.
// Holds the channel index and hue ramp segment codes; no dependencies.
package h2r_pkg;

  // Number of color channels carried per beat
  localparam int NUM_CH = 3;

  // Channel slot inside per-channel arrays
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  // Piecewise hue ramp segment
  typedef enum logic [1:0] {
    SEG_RISE   = 2'd0,
    SEG_HOLD_Q = 2'd1,
    SEG_FALL   = 2'd2,
    SEG_HOLD_P = 2'd3
  } seg_t;

endpackage

[rtl/h2r_front.sv]
// h2r_front: accepts HSL beats, forms q/p/d and the three hue phases.
// Two register stages feeding the queue; uses h2r_pkg.
module h2r_front #(
  parameter int CHANNEL_BITS = 8,
  localparam int N       = CHANNEL_BITS,
  localparam int PW      = N + 2,
  localparam int ENTRY_W = 1 + 5 * N + 3 * PW
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [N-1:0]       hue,
  input  logic [N-1:0]       saturation,
  input  logic [N-1:0]       lightness,
  output logic               push_valid,
  input  logic               push_ready,
  output logic [ENTRY_W-1:0] push_data
);

  localparam int ONE = 2 ** N;
  localparam int QW  = 2 * N + 1;
  localparam logic [N:0]    MAX_R    = (N + 1)'(ONE - 1);
  localparam logic [PW:0]   ONE_S    = (PW + 1)'(ONE);
  localparam logic [PW:0]   TWO_S    = (PW + 1)'(2 * ONE);
  localparam logic [PW:0]   PERIOD_S = (PW + 1)'(3 * ONE);

  // stage 1 registers
  logic              fv1;
  logic              grey1;
  logic [N-1:0]      l1;
  logic [2*N-1:0]    q1;
  logic [PW-1:0]     ph1 [h2r_pkg::NUM_CH];
  // stage 2 registers
  logic              fv2;
  logic [ENTRY_W-1:0] entry2;

  logic              f1_adv;
  logic              f2_adv;

  // stage 1 combinational
  logic              low;
  logic [N-1:0]      mul_a;
  logic [N:0]        mul_b;
  logic [QW-1:0]     prod;
  logic [QW-1:0]     lm;
  logic [QW-1:0]     q_sum;
  logic [PW:0]       base;
  logic [PW:0]       plus1;
  logic [PW:0]       plus2;
  logic [PW-1:0]     ph_n [h2r_pkg::NUM_CH];

  // stage 2 combinational
  logic [QW-1:0]     lm1;
  logic [QW-1:0]     two_lm;
  logic [QW-1:0]     p_wide;
  logic [2*N-1:0]    p_n;
  logic [2*N-1:0]    d_n;

  // handshake chain
  assign f2_adv     = !fv2 || push_ready;
  assign f1_adv     = !fv1 || f2_adv;
  assign in_ready   = f1_adv;
  assign push_valid = fv2;
  assign push_data  = entry2;

  // q from l and s; the lightness split is 2*l < M
  always_comb begin
    low = {lightness, 1'b0} < MAX_R;
    if (low) begin
      mul_a = lightness;
      mul_b = MAX_R + (N + 1)'(saturation);
    end else begin
      mul_a = saturation;
      mul_b = MAX_R - (N + 1)'(lightness);
    end
    prod  = QW'(mul_a) * QW'(mul_b);
    lm    = (QW'(lightness) << N) - QW'(lightness);
    q_sum = low ? prod : prod + lm;
  end

  // hue phases in units of 1/(3H), wrapped into one period
  always_comb begin
    base  = ((PW + 1)'(hue) << 1) + (PW + 1)'(hue);
    plus1 = base + ONE_S;
    plus2 = base + TWO_S;
    ph_n[h2r_pkg::CH_RED]   = PW'((plus1 >= PERIOD_S) ? plus1 - PERIOD_S : plus1);
    ph_n[h2r_pkg::CH_GREEN] = PW'(base);
    ph_n[h2r_pkg::CH_BLUE]  = PW'((plus2 >= PERIOD_S) ? plus2 - PERIOD_S : plus2);
  end

  // p = 2lM - q, d = q - p
  always_comb begin
    lm1    = (QW'(l1) << N) - QW'(l1);
    two_lm = lm1 << 1;
    p_wide = two_lm - QW'(q1);
    p_n    = p_wide[2*N-1:0];
    d_n    = q1 - p_n;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      fv1 <= 1'b0;
      fv2 <= 1'b0;
    end else begin
      if (f1_adv) fv1 <= in_valid;
      if (f2_adv) fv2 <= fv1;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (f1_adv && in_valid) begin
      grey1 <= (saturation == '0);
      l1    <= lightness;
      q1    <= q_sum[2*N-1:0];
      for (int c = 0; c < h2r_pkg::NUM_CH; c++) ph1[c] <= ph_n[c];
    end
    if (f2_adv && fv1) begin
      entry2 <= {grey1, l1, p_n, d_n,
                 ph1[h2r_pkg::CH_RED], ph1[h2r_pkg::CH_GREEN], ph1[h2r_pkg::CH_BLUE]};
    end
  end

endmodule

[rtl/h2r_queue.sv]
// h2r_queue: two-entry queue between front and back halves.
// Register-based storage with count; no package dependencies.
module h2r_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL  = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("queue count above depth");
  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 1'b1)
    else $error("queue count did not drop on pop");
  a_push_inc: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not rise on push");

endmodule

[rtl/h2r_back.sv]
// h2r_back: runs the hue ramp per channel and scales to channel bytes.
// Three register stages, last one is the output register; uses h2r_pkg.
module h2r_back #(
  parameter int CHANNEL_BITS = 8,
  localparam int N       = CHANNEL_BITS,
  localparam int PW      = N + 2,
  localparam int ENTRY_W = 1 + 5 * N + 3 * PW
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  logic [ENTRY_W-1:0] pop_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [N-1:0]       red,
  output logic [N-1:0]       green,
  output logic [N-1:0]       blue
);

  localparam int ONE = 2 ** N;
  localparam int UW  = N + 1;
  localparam int PRW = 3 * N + 1;
  localparam int XW  = 2 * N;
  localparam logic [PW-1:0] T_SIXTH = PW'(ONE / 2);
  localparam logic [PW-1:0] T_HALF  = PW'(3 * ONE / 2);
  localparam logic [PW-1:0] T_TWO3  = PW'(2 * ONE);
  localparam logic [N:0]    MAX_R   = (N + 1)'(ONE - 1);

  // unpacked queue entry
  logic              e_grey;
  logic [N-1:0]      e_l;
  logic [XW-1:0]     e_p;
  logic [XW-1:0]     e_d;
  logic [PW-1:0]     e_ph [h2r_pkg::NUM_CH];

  // stage 1: segment and product
  logic              bv1;
  logic              grey1;
  logic [N-1:0]      l1;
  logic [XW-1:0]     p1;
  logic [XW-1:0]     d1;
  h2r_pkg::seg_t     seg1  [h2r_pkg::NUM_CH];
  logic [PRW-1:0]    prod1 [h2r_pkg::NUM_CH];
  // stage 2: ramp value over M*M
  logic              bv2;
  logic              grey2;
  logic [N-1:0]      l2;
  logic [XW-1:0]     p2;
  logic [XW-1:0]     d2;
  logic [XW-1:0]     x2    [h2r_pkg::NUM_CH];
  // stage 3: output register
  logic              bv3;
  logic              grey3;

  logic              adv1;
  logic              adv2;
  logic              adv3;

  h2r_pkg::seg_t     seg_n  [h2r_pkg::NUM_CH];
  logic [PRW-1:0]    prod_n [h2r_pkg::NUM_CH];
  logic [XW-1:0]     x_n    [h2r_pkg::NUM_CH];
  logic [N-1:0]      ch_n   [h2r_pkg::NUM_CH];

  assign e_grey = pop_data[ENTRY_W-1];
  assign e_l    = pop_data[ENTRY_W-2 -: N];
  assign e_p    = pop_data[ENTRY_W-2-N -: XW];
  assign e_d    = pop_data[ENTRY_W-2-3*N -: XW];
  assign e_ph[h2r_pkg::CH_RED]   = pop_data[3*PW-1 -: PW];
  assign e_ph[h2r_pkg::CH_GREEN] = pop_data[2*PW-1 -: PW];
  assign e_ph[h2r_pkg::CH_BLUE]  = pop_data[PW-1:0];

  // handshake chain
  assign adv3      = !bv3 || out_ready;
  assign adv2      = !bv2 || adv3;
  assign adv1      = !bv1 || adv2;
  assign pop_ready = adv1;
  assign out_valid = bv3;

  // stage 1: classify phase and multiply d by the ramp slope
  always_comb begin
    for (int c = 0; c < h2r_pkg::NUM_CH; c++) begin
      logic [UW-1:0] u;
      logic [PW-1:0] diff;
      diff = T_TWO3 - e_ph[c];
      u    = '0;
      priority if (e_ph[c] < T_SIXTH) begin
        seg_n[c] = h2r_pkg::SEG_RISE;
        u        = UW'({e_ph[c], 1'b0});
      end else if (e_ph[c] < T_HALF) begin
        seg_n[c] = h2r_pkg::SEG_HOLD_Q;
      end else if (e_ph[c] < T_TWO3) begin
        seg_n[c] = h2r_pkg::SEG_FALL;
        u        = UW'({diff, 1'b0});
      end else begin
        seg_n[c] = h2r_pkg::SEG_HOLD_P;
      end
      prod_n[c] = PRW'(e_d) * PRW'(u);
    end
  end

  // stage 2: value numerator over M*M, exact floor of the 1/H part
  always_comb begin
    for (int c = 0; c < h2r_pkg::NUM_CH; c++) begin
      unique case (seg1[c])
        h2r_pkg::SEG_RISE,
        h2r_pkg::SEG_FALL:   x_n[c] = p1 + prod1[c][3*N-1:N];
        h2r_pkg::SEG_HOLD_Q: x_n[c] = p1 + d1;
        h2r_pkg::SEG_HOLD_P: x_n[c] = p1;
        default:             x_n[c] = p1;
      endcase
    end
  end

  // stage 3: floor(x / M) with one correction step
  always_comb begin
    for (int c = 0; c < h2r_pkg::NUM_CH; c++) begin
      logic [N-1:0] q0;
      logic [N:0]   r;
      q0 = x2[c][XW-1:N];
      r  = {1'b0, x2[c][N-1:0]} + {1'b0, q0};
      ch_n[c] = q0 + N'(r >= MAX_R);
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      bv1 <= 1'b0;
      bv2 <= 1'b0;
      bv3 <= 1'b0;
    end else begin
      if (adv1) bv1 <= pop_valid;
      if (adv2) bv2 <= bv1;
      if (adv3) bv3 <= bv2;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv1 && pop_valid) begin
      grey1 <= e_grey;
      l1    <= e_l;
      p1    <= e_p;
      d1    <= e_d;
      for (int c = 0; c < h2r_pkg::NUM_CH; c++) begin
        seg1[c]  <= seg_n[c];
        prod1[c] <= prod_n[c];
      end
    end
    if (adv2 && bv1) begin
      grey2 <= grey1;
      l2    <= l1;
      p2    <= p1;
      d2    <= d1;
      for (int c = 0; c < h2r_pkg::NUM_CH; c++) x2[c] <= x_n[c];
    end
    if (adv3 && bv2) begin
      grey3 <= grey2;
      red   <= grey2 ? l2 : ch_n[h2r_pkg::CH_RED];
      green <= grey2 ? l2 : ch_n[h2r_pkg::CH_GREEN];
      blue  <= grey2 ? l2 : ch_n[h2r_pkg::CH_BLUE];
    end
  end

  a_grey_equal: assert property (@(posedge clk) disable iff (rst)
    (bv3 && grey3) |-> (red == green && green == blue))
    else $error("grey beat with unequal channels");
  a_x_below_hm: assert property (@(posedge clk) disable iff (rst)
    bv2 |-> (x2[0][XW-1:N] != '1 && x2[1][XW-1:N] != '1 && x2[2][XW-1:N] != '1))
    else $error("ramp value out of range for scaling");
  a_x_between: assert property (@(posedge clk) disable iff (rst)
    (bv2 && !grey2) |-> (x2[0] >= p2 && x2[1] >= p2 && x2[2] >= p2 &&
                         (XW + 1)'(x2[0]) <= (XW + 1)'(p2) + (XW + 1)'(d2) &&
                         (XW + 1)'(x2[1]) <= (XW + 1)'(p2) + (XW + 1)'(d2) &&
                         (XW + 1)'(x2[2]) <= (XW + 1)'(p2) + (XW + 1)'(d2)))
    else $error("ramp value outside p..q");

endmodule

[rtl/hsl_to_rgb_converter_core.sv]
// hsl_to_rgb_converter_core: top level of the HSL to RGB converter.
// Instantiates h2r_front, h2r_queue and h2r_back; uses h2r_pkg via them.
//
// Usage:
//   Input channel in_valid/in_ready carries hue, saturation, lightness,
//   each CHANNEL_BITS wide. Output channel out_valid/out_ready carries
//   red, green, blue of the same width. One result beat per input beat,
//   in order. Zero saturation gives grey at the lightness level.
//   Throughput: one beat per clock, sustained, when out_ready stays high.
//   Path from input acceptance to out_valid, empty pipeline: six
//   registers, the first loaded at the accepting edge - two front
//   stages (q multiply, p/d), the two-entry queue, and three back stages
//   (ramp multiply, ramp add, scale by 1/M into the output register).
//   When the receiver stalls, the back stages hold and the queue fills;
//   the front keeps accepting until the queue and its own two stages are
//   full, then in_ready drops. The output beat stays stable while stalled.
//   Reset (rst, synchronous) empties all stages and the queue; no beat is
//   in flight afterward and in_ready is high the next cycle.
module hsl_to_rgb_converter_core #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CHANNEL_BITS-1:0] hue,
  input  logic [CHANNEL_BITS-1:0] saturation,
  input  logic [CHANNEL_BITS-1:0] lightness,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CHANNEL_BITS-1:0] red,
  output logic [CHANNEL_BITS-1:0] green,
  output logic [CHANNEL_BITS-1:0] blue
);

  localparam int ENTRY_W = 1 + 5 * CHANNEL_BITS + 3 * (CHANNEL_BITS + 2);

  logic               f_valid;
  logic               f_ready;
  logic [ENTRY_W-1:0] f_data;
  logic               b_valid;
  logic               b_ready;
  logic [ENTRY_W-1:0] b_data;

  // front: accept and precompute
  h2r_front #(.CHANNEL_BITS(CHANNEL_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data)
  );

  // decoupling queue
  h2r_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  // back: hue ramp and scaling
  h2r_back #(.CHANNEL_BITS(CHANNEL_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_data  (b_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

endmodule
